### hdl/swst_pkg.sv
// Shared types, constants and codes for the sliding window sequence tracker.
`default_nettype none
package swst_pkg;

  localparam int WINDOW    = 128;
  localparam int SEQ_BITS  = 8;
  localparam int SLOT_BITS = $clog2(WINDOW);
  localparam int ADV_BITS  = $clog2(WINDOW + 1);
  localparam int SEQ_MASK  = (1 << SEQ_BITS) - 1;
  localparam int LIMIT     = (WINDOW < SEQ_MASK) ? WINDOW : SEQ_MASK;

  // run scan chunk: the map is walked this many bits per cycle
  localparam int SCAN_W    = 16;
  localparam int SCAN_BITS = $clog2(SCAN_W + 1);

  localparam logic [SEQ_BITS:0] WIN_CMP   = (SEQ_BITS + 1)'(WINDOW);
  localparam logic [SEQ_BITS:0] LIMIT_CMP = (SEQ_BITS + 1)'(LIMIT);

  localparam logic [1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [1:0] OP_TRANSMIT = 2'd1;
  localparam logic [1:0] OP_RECEIVE  = 2'd2;
  localparam logic [1:0] OP_CONSUME  = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [SEQ_BITS-1:0] frame_seq;
    logic [SEQ_BITS-1:0] frame_ack;
    logic                frame_ok;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [SEQ_BITS-1:0]  seq_out;
    logic [SLOT_BITS-1:0] slot_out;
    logic [SEQ_BITS-1:0]  ack_out;
    logic [ADV_BITS-1:0]  advanced;
    logic [SEQ_BITS-1:0]  in_flight;
    logic [SEQ_BITS-1:0]  unprocessed;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } stat_t;

endpackage
`default_nettype wire

### hdl/swst_ctrl.sv
// Control state machine: sequences accept, run scan and result hand-off.
`default_nettype none
module swst_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output swst_pkg::cmd_t      cmd,
  input  wire swst_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  always_comb begin
    cmd.accept = (state == S_IDLE) && req_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.load   = (state == S_FIN) && (!rsp_valid || !rsp_stall);
    req_stall  = (state != S_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          state_next = stat.need_scan ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (cmd.load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.load) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule
`default_nettype wire

### hdl/swst_dp.sv
// Datapath: sequence counters, arrival bitmap, run scanner and result register.
`default_nettype none
module swst_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire swst_pkg::req_t  req,
  output swst_pkg::rsp_t       rsp,
  input  wire swst_pkg::cmd_t  cmd,
  output swst_pkg::stat_t      stat
);

  localparam int SB = swst_pkg::SEQ_BITS;
  localparam int LB = swst_pkg::SLOT_BITS;
  localparam int AB = swst_pkg::ADV_BITS;
  localparam int W  = swst_pkg::WINDOW;
  localparam int CW = swst_pkg::SCAN_W;
  localparam int CB = swst_pkg::SCAN_BITS;

  logic [SB-1:0] next_own_seq, next_to_send, last_acked, expected_seq, consumed_seq;
  logic [W-1:0]  arrival_map;
  logic [1:0]    status;
  logic [SB-1:0] seq;
  logic [AB-1:0] adv;

  // step decision
  logic [SB-1:0] own_gap, send_gap, ack_gap, rx_gap, seq_gap;
  logic          full_send, none_send, rx_full, ack_bad, seq_in_win;
  logic          reject;
  logic          need_scan;
  logic [1:0]    status_next;
  logic [SB-1:0] seq_next;

  always_comb begin
    own_gap    = next_own_seq - last_acked;
    send_gap   = next_to_send - last_acked;
    ack_gap    = req.frame_ack - last_acked;
    rx_gap     = expected_seq - consumed_seq;
    seq_gap    = req.frame_seq - expected_seq;
    full_send  = {1'b0, own_gap} >= swst_pkg::LIMIT_CMP;
    none_send  = (next_own_seq == next_to_send) || ({1'b0, send_gap} >= swst_pkg::WIN_CMP);
    rx_full    = {1'b0, rx_gap} >= swst_pkg::WIN_CMP;
    ack_bad    = {1'b0, ack_gap} >= swst_pkg::WIN_CMP;
    seq_in_win = {1'b0, seq_gap} < swst_pkg::WIN_CMP;
    reject     = rx_full || !req.frame_ok || ack_bad;

    status_next = swst_pkg::ST_DONE;
    seq_next    = '0;
    unique case (req.op)
      swst_pkg::OP_ENQUEUE: begin
        if (full_send) status_next = swst_pkg::ST_EMPTY;
        else           seq_next    = next_own_seq;
      end
      swst_pkg::OP_TRANSMIT: begin
        if (none_send) status_next = swst_pkg::ST_EMPTY;
        else           seq_next    = next_to_send;
      end
      swst_pkg::OP_RECEIVE: begin
        if (reject) status_next = swst_pkg::ST_REJECT;
        else        seq_next    = req.frame_seq;
      end
      swst_pkg::OP_CONSUME: begin
        if (rx_gap == '0) status_next = swst_pkg::ST_EMPTY;
        else              seq_next    = consumed_seq;
      end
      default: status_next = swst_pkg::ST_EMPTY;
    endcase

    need_scan = (req.op == swst_pkg::OP_RECEIVE) && !reject && seq_in_win;
  end

  // run scanner: count trailing ones of the low chunk
  logic [CW-1:0] chunk;
  logic          chunk_full;
  logic [CB-1:0] chunk_ones, step;

  always_comb begin
    chunk      = arrival_map[CW-1:0];
    chunk_full = &chunk;
    chunk_ones = '0;
    for (int i = CW - 1; i >= 0; i--) begin
      if (!chunk[i]) chunk_ones = CB'(i);
    end
    step = chunk_full ? CB'(CW) : chunk_ones;
  end

  always_comb begin
    stat.need_scan = need_scan;
    stat.scan_done = !chunk_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_own_seq <= '0;
      next_to_send <= '0;
      last_acked   <= '0;
      expected_seq <= '0;
      consumed_seq <= '0;
      arrival_map  <= '0;
    end else if (cmd.accept) begin
      if (status_next == swst_pkg::ST_DONE) begin
        unique case (req.op)
          swst_pkg::OP_ENQUEUE:  next_own_seq <= next_own_seq + 1'b1;
          swst_pkg::OP_TRANSMIT: next_to_send <= next_to_send + 1'b1;
          swst_pkg::OP_RECEIVE: begin
            last_acked <= req.frame_ack;
            if (seq_in_win) arrival_map[seq_gap[LB-1:0]] <= 1'b1;
          end
          swst_pkg::OP_CONSUME:  consumed_seq <= consumed_seq + 1'b1;
          default: ;
        endcase
      end
    end else if (cmd.scan) begin
      arrival_map  <= arrival_map >> step;
      expected_seq <= expected_seq + SB'(step);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status <= status_next;
      seq    <= seq_next;
      adv    <= '0;
    end else if (cmd.scan) begin
      adv <= adv + AB'(step);
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.status      <= status;
      rsp.seq_out     <= seq;
      rsp.slot_out    <= seq[LB-1:0];
      rsp.ack_out     <= expected_seq;
      rsp.advanced    <= adv;
      rsp.in_flight   <= own_gap;
      rsp.unprocessed <= rx_gap;
    end
  end

endmodule
`default_nettype wire

### hdl/sliding_window_seq_tracker.sv
// Top level of the sliding window sequence tracker.
// Sequence bookkeeping for a selective-repeat link with 8-bit sequence
// numbers and a 128-entry window. Each request beat (enqueue, transmit,
// frame received, consume) yields exactly one response beat with the
// status, the sequence number and slot involved, the current ack, how far
// the expected number moved, and the in-flight and unprocessed counts.
// Every item goes from accept straight to the result hand-off, except an
// accepted in-window received frame, which first walks the arrival bitmap
// 16 bits per cycle until the walk meets a zero bit. The
// next request is taken once the previous response sits in the output
// register, even while that response is stalled; a finished result that
// finds that register still held waits until that response is taken.
`default_nettype none
module sliding_window_seq_tracker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire swst_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output swst_pkg::rsp_t      rsp
);

  swst_pkg::cmd_t  cmd;
  swst_pkg::stat_t stat;

  swst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  swst_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for the sliding window sequence tracker: directed table, random phases, predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swst_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    req_t stim;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  sliding_window_seq_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the tracker state
  logic [SEQ_BITS-1:0] own_seq     = '0;
  logic [SEQ_BITS-1:0] send_seq    = '0;
  logic [SEQ_BITS-1:0] acked_seq   = '0;
  logic [SEQ_BITS-1:0] rx_expected = '0;
  logic [SEQ_BITS-1:0] rx_consumed = '0;
  logic [WINDOW-1:0]   arrival_bits = '0;

  rsp_t       expected_rsp_q[$];
  plan_row_t  plan[$];
  idle_mode_e idle_mode = IDLE_NONE;
  bit         hold_req = 1'b0;
  int         mismatches = 0;
  int         beats_sent = 0;
  int         beats_checked = 0;
  int         status_seen[3] = '{0, 0, 0};
  int         max_advance = 0;
  rsp_t       want_rsp;

  function automatic logic [SEQ_BITS-1:0] seq_gap(logic [SEQ_BITS-1:0] a,
                                                   logic [SEQ_BITS-1:0] b);
    return a - b;
  endfunction

  function automatic rsp_t predict_bookkeeping(req_t r);
    rsp_t o;
    logic [SEQ_BITS-1:0] gap;
    int moved;
    o = '0;
    moved = 0;
    case (r.op)
      OP_ENQUEUE: begin
        if (seq_gap(own_seq, acked_seq) >= LIMIT) begin
          o.status = ST_EMPTY;
        end else begin
          o.seq_out = own_seq;
          own_seq = own_seq + 1'b1;
        end
      end
      OP_TRANSMIT: begin
        if (seq_gap(own_seq, send_seq) == 0 || seq_gap(send_seq, acked_seq) >= WINDOW) begin
          o.status = ST_EMPTY;
        end else begin
          o.seq_out = send_seq;
          send_seq = send_seq + 1'b1;
        end
      end
      OP_RECEIVE: begin
        if (seq_gap(rx_expected, rx_consumed) >= WINDOW || !r.frame_ok ||
            seq_gap(r.frame_ack, acked_seq) >= WINDOW) begin
          o.status = ST_REJECT;
        end else begin
          acked_seq = r.frame_ack;
          o.seq_out = r.frame_seq;
          gap = seq_gap(r.frame_seq, rx_expected);
          // far or stale numbers leave the map alone
          if (gap < WINDOW) begin
            arrival_bits[gap] = 1'b1;
            while (arrival_bits[0] && moved < WINDOW) begin
              rx_expected = rx_expected + 1'b1;
              arrival_bits = arrival_bits >> 1;
              moved++;
            end
          end
        end
      end
      default: begin
        if (seq_gap(rx_expected, rx_consumed) == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.seq_out = rx_consumed;
          rx_consumed = rx_consumed + 1'b1;
        end
      end
    endcase
    if (o.status == ST_DONE) o.slot_out = SLOT_BITS'(o.seq_out % WINDOW);
    o.ack_out     = rx_expected;
    o.advanced    = ADV_BITS'(moved);
    o.in_flight   = seq_gap(own_seq, acked_seq);
    o.unprocessed = seq_gap(rx_expected, rx_consumed);
    return o;
  endfunction

  function automatic void add_row(logic [1:0] op, int fseq, int fack, bit ok,
                                  bit typed = 1'b0, logic [1:0] st = ST_DONE,
                                  int so = 0, int sl = 0, int ao = 0, int adv = 0,
                                  int inf = 0, int unp = 0);
    plan_row_t row;
    row.stim.op          = op;
    row.stim.frame_seq   = SEQ_BITS'(fseq);
    row.stim.frame_ack   = SEQ_BITS'(fack);
    row.stim.frame_ok    = ok;
    row.typed            = typed;
    row.want.status      = st;
    row.want.seq_out     = SEQ_BITS'(so);
    row.want.slot_out    = SLOT_BITS'(sl);
    row.want.ack_out     = SEQ_BITS'(ao);
    row.want.advanced    = ADV_BITS'(adv);
    row.want.in_flight   = SEQ_BITS'(inf);
    row.want.unprocessed = SEQ_BITS'(unp);
    plan.push_back(row);
  endfunction

  function automatic req_t noise_item();
    req_t r;
    r.op        = 2'($urandom_range(3));
    r.frame_seq = SEQ_BITS'($urandom);
    r.frame_ack = SEQ_BITS'($urandom);
    r.frame_ok  = 1'($urandom);
    return r;
  endfunction

  // well-formed frame: ack inside the window, number near the expected one
  function automatic req_t frame_item();
    req_t r;
    int room;
    int pick;
    r = noise_item();
    r.op = OP_RECEIVE;
    r.frame_ok = 1'b1;
    room = seq_gap(own_seq, acked_seq);
    if (room > WINDOW - 1) room = WINDOW - 1;
    r.frame_ack = acked_seq + SEQ_BITS'($urandom_range(0, room));
    pick = $urandom_range(99);
    if (pick < 75) r.frame_seq = rx_expected + SEQ_BITS'($urandom_range(0, 15));
    else if (pick < 92) r.frame_seq = rx_expected + SEQ_BITS'($urandom_range(0, WINDOW - 1));
    else r.frame_seq = rx_expected - SEQ_BITS'($urandom_range(1, 20));
    return r;
  endfunction

  function automatic req_t mix_item(int p_enq, int p_tx, int p_rx);
    req_t r;
    int pick;
    r = noise_item();
    if ($urandom_range(99) < 12) return r;
    pick = $urandom_range(99);
    if (pick < p_enq) r.op = OP_ENQUEUE;
    else if (pick < p_enq + p_tx) r.op = OP_TRANSMIT;
    else if (pick < p_enq + p_tx + p_rx) r = frame_item();
    else r.op = OP_CONSUME;
    return r;
  endfunction

  function automatic int send_gap_pct();
    return (idle_mode == IDLE_SEND) ? 71 : (idle_mode == IDLE_BOTH) ? 29 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (idle_mode == IDLE_RECV) ? 71 : (idle_mode == IDLE_BOTH) ? 29 : 0;
  endfunction

  // enter and leave at a falling edge; hold the beat until it is taken
  task automatic send_beat(req_t r, bit typed = 1'b0, rsp_t typed_rsp = '0);
    rsp_t p;
    while ($urandom_range(99) < send_gap_pct()) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    p = predict_bookkeeping(r);
    expected_rsp_q.push_back(typed ? typed_rsp : p);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        rsp_stall = ($urandom_range(99) < recv_stall_pct());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: response beat with nothing expected", $realtime);
      end else begin
        want_rsp = expected_rsp_q.pop_front();
        beats_checked++;
        if (rsp.status !== want_rsp.status || rsp.seq_out !== want_rsp.seq_out ||
            rsp.slot_out !== want_rsp.slot_out || rsp.ack_out !== want_rsp.ack_out ||
            rsp.advanced !== want_rsp.advanced || rsp.in_flight !== want_rsp.in_flight ||
            rsp.unprocessed !== want_rsp.unprocessed) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch want st=%0d seq=%0d slot=%0d ack=%0d adv=%0d ",
                      "infl=%0d unp=%0d, got st=%0d seq=%0d slot=%0d ack=%0d adv=%0d ",
                      "infl=%0d unp=%0d"}, $realtime,
                     want_rsp.status, want_rsp.seq_out, want_rsp.slot_out,
                     want_rsp.ack_out, want_rsp.advanced, want_rsp.in_flight,
                     want_rsp.unprocessed, rsp.status, rsp.seq_out, rsp.slot_out,
                     rsp.ack_out, rsp.advanced, rsp.in_flight, rsp.unprocessed);
        end
        if (rsp.status < 3) status_seen[rsp.status]++;
        if (int'(rsp.advanced) > max_advance) max_advance = rsp.advanced;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    req_t r;
    int extra;
    int offs;

    // nothing pending, bad frames, first messages, stale and edge-of-window numbers
    add_row(OP_CONSUME,  0,    0,    1, 1, ST_EMPTY,  0, 0, 0, 0, 0, 0);
    add_row(OP_TRANSMIT, 8'hFF, 8'hFF, 1, 1, ST_EMPTY, 0, 0, 0, 0, 0, 0);
    add_row(OP_RECEIVE,  0,    0,    0, 1, ST_REJECT, 0, 0, 0, 0, 0, 0);
    add_row(OP_RECEIVE,  0,    8'h80, 1, 1, ST_REJECT, 0, 0, 0, 0, 0, 0);
    add_row(OP_RECEIVE,  8'hFF, 8'hFF, 1, 1, ST_REJECT, 0, 0, 0, 0, 0, 0);
    add_row(OP_ENQUEUE,  8'hFF, 8'hFF, 0, 1, ST_DONE,   0, 0, 0, 0, 1, 0);
    add_row(OP_ENQUEUE,  0,    0,    1, 1, ST_DONE,   1, 1, 0, 0, 2, 0);
    add_row(OP_TRANSMIT, 0,    0,    0, 1, ST_DONE,   0, 0, 0, 0, 2, 0);
    add_row(OP_RECEIVE,  0,    0,    1, 1, ST_DONE,   0, 0, 1, 1, 2, 1);
    add_row(OP_RECEIVE,  0,    0,    1, 1, ST_DONE,   0, 0, 1, 0, 2, 1);
    add_row(OP_RECEIVE,  3,    1,    1);
    add_row(OP_RECEIVE,  3,    1,    1);
    add_row(OP_RECEIVE,  2,    1,    1);
    add_row(OP_RECEIVE,  1,    1,    1);
    add_row(OP_RECEIVE,  8'h83, 1,    1);
    add_row(OP_RECEIVE,  8'h84, 1,    1);
    add_row(OP_RECEIVE,  8'hFF, 8'h7F, 1);
    add_row(OP_ENQUEUE,  0,    0,    1);
    add_row(OP_TRANSMIT, 0,    0,    1);
    add_row(OP_RECEIVE,  4,    1,    1);
    add_row(OP_RECEIVE,  4,    8'hC0, 1);
    add_row(OP_RECEIVE,  5,    2,    1);
    add_row(OP_CONSUME,  0,    0,    1);
    add_row(OP_CONSUME,  8'hFF, 8'hFF, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) send_beat(plan[i].stim, plan[i].typed, plan[i].want);
    wait_drained();

    // fill the send window until enqueue is refused
    idle_mode = IDLE_NONE;
    extra = 0;
    for (int guard = 0; guard < 300 && extra < 6; guard++) begin
      r = noise_item();
      r.op = ($urandom_range(99) < 88) ? OP_ENQUEUE : OP_TRANSMIT;
      send_beat(r);
      if (seq_gap(own_seq, acked_seq) >= LIMIT) extra++;
    end
    wait_drained();

    idle_mode = IDLE_SEND;
    repeat (50) send_beat(mix_item(20, 25, 40));
    wait_drained();

    // long hold-off while draining, then fill the bitmap back to front
    idle_mode = IDLE_RECV;
    hold_req = 1'b1;
    for (int guard = 0; guard < 300 && seq_gap(rx_expected, rx_consumed) != 0; guard++) begin
      r = noise_item();
      r.op = OP_CONSUME;
      send_beat(r);
    end
    offs = WINDOW - 1;
    while (offs > 0) begin
      r = frame_item();
      r.frame_seq = rx_expected + SEQ_BITS'(offs);
      send_beat(r);
      if ($urandom_range(99) >= 5) offs--;
    end
    r = frame_item();
    r.frame_seq = rx_expected;
    send_beat(r);
    // receive buffer is full now
    repeat (3) send_beat(frame_item());
    wait_drained();

    idle_mode = IDLE_BOTH;
    repeat (50) send_beat(mix_item(15, 15, 25));
    wait_drained();

    repeat (24) @(posedge clk);
    $display("Sent %0d request beats, checked %0d response beats (%0d mismatches).",
             beats_sent, beats_checked, mismatches);
    $display("Status done/empty-or-full/reject: %0d/%0d/%0d, largest advance %0d.",
             status_seen[0], status_seen[1], status_seen[2], max_advance);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
